// ----- sv/vqncs_pkg.sv -----
// vqncs_pkg: shared types and constants of the nearest codeword search
// no dependencies, compiled first
`default_nettype none

package vqncs_pkg;

  // fixed geometry of one codebook entry
  localparam int LANES       = 4;   // pixels per 2x2 quad, one lane each
  localparam int CH_W        = 8;   // one ARGB channel
  localparam int CHANNELS    = 4;   // channels per pixel
  localparam int PIX_W       = 32;
  localparam int IDX_W       = 8;
  localparam int LANE_DIST_W = 18;  // 4 * 255^2 fits in 18 bits
  localparam int DIST_W      = 20;  // 16 * 255^2 fits in 20 bits
  localparam int CNT_W       = 9;   // entries_in_use register

  localparam int DEFAULT_CODEBOOK_DEPTH = 256;
  localparam logic [CNT_W-1:0] ENTRIES_RESET = 9'd256;

  // func codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_HOLD
  } state_t;

  // control that travels alongside the datapath pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] index;
  } tag_t;

endpackage

`default_nettype wire

// ----- sv/vqncs_if.sv -----
// vqncs interfaces: request, response and configuration channels
// depends on vqncs_pkg
`default_nettype none

interface vqncs_req_if
  import vqncs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             func;
  logic [IDX_W-1:0] entry_index;
  logic [PIX_W-1:0] pixel_top_left;
  logic [PIX_W-1:0] pixel_top_right;
  logic [PIX_W-1:0] pixel_bottom_left;
  logic [PIX_W-1:0] pixel_bottom_right;

  modport source (
    output valid, func, entry_index, pixel_top_left, pixel_top_right,
           pixel_bottom_left, pixel_bottom_right,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, pixel_top_left, pixel_top_right,
           pixel_bottom_left, pixel_bottom_right,
    output ready
  );
endinterface

interface vqncs_rsp_if
  import vqncs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  code_index;
  logic [DIST_W-1:0] distance_squared;

  modport source (output valid, code_index, distance_squared, input ready);
  modport sink   (input  valid, code_index, distance_squared, output ready);
endinterface

interface vqncs_cfg_if
  import vqncs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input  valid, data, output ready);
endinterface

`default_nettype wire

// ----- sv/vq_nearest_codeword_search.sv -----
// vq_nearest_codeword_search: full-search vector quantizer top level
// depends on vqncs_pkg, vqncs_if, vqncs_lane, vqncs_merge
//
//   channel  dir  transaction carries
//   req      in   func, entry_index, four ARGB8888 quad pixels
//   rsp      out  code_index, distance_squared (one per search)
//   cfg      in   entries_in_use write
//
// a search reads entries 0 to N-1 one entry per cycle, set by the single read
// port of each lane memory; loads are taken only while idle
// rst is synchronous: state machine, pipeline tags, output valid and
// entries_in_use (back to 256) reset; codebook memories keep garbage
// a waiting result holds in the output register; loads are still taken then
`default_nettype none

module vq_nearest_codeword_search
  import vqncs_pkg::*;
#(
  parameter int CODEBOOK_DEPTH = DEFAULT_CODEBOOK_DEPTH
) (
  input wire logic clk,
  input wire logic rst,
  vqncs_req_if.sink   req,
  vqncs_rsp_if.source rsp,
  vqncs_cfg_if.sink   cfg
);

  localparam int AW = $clog2(CODEBOOK_DEPTH);

  // configuration register
  logic [CNT_W-1:0] entries_in_use;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= ENTRIES_RESET;
    end else if (cfg.valid && cfg.ready) begin
      entries_in_use <= cfg.data;
    end
  end

  // sequencer
  state_t state;
  state_t state_next;
  logic   in_ready;
  logic   rd_en;
  logic   out_load;
  logic   done;

  logic [AW-1:0] cnt;
  logic [AW-1:0] last_addr;
  logic [AW-1:0] last_addr_next;

  logic req_fire;
  logic search_start;
  logic wr_en;

  assign req.ready    = in_ready;
  assign req_fire     = req.valid && req.ready;
  assign search_start = req_fire && (req.func == FUNC_SEARCH);
  // loads beyond the codebook are dropped
  assign wr_en        = req_fire && (req.func == FUNC_LOAD)
                        && ({1'b0, req.entry_index} < CNT_W'(CODEBOOK_DEPTH));

  // clamp entries_in_use to 1 .. CODEBOOK_DEPTH, keep the last address
  always_comb begin
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] lim_m1;
    lim = entries_in_use;
    if (lim == '0) begin
      lim = CNT_W'(1);
    end else if (lim > CNT_W'(CODEBOOK_DEPTH)) begin
      lim = CNT_W'(CODEBOOK_DEPTH);
    end
    lim_m1 = lim - CNT_W'(1);
    last_addr_next = lim_m1[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (search_start) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (cnt == last_addr) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (done) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    rd_en    = (state == ST_SEARCH);
    out_load = (state == ST_HOLD) && (!rsp.valid || rsp.ready);
  end

  // entry counter and search bounds
  always_ff @(posedge clk) begin
    if (search_start) begin
      cnt       <= '0;
      last_addr <= last_addr_next;
    end else if (rd_en) begin
      cnt <= cnt + AW'(1);
    end
  end

  // quad held for the whole search
  logic [PIX_W-1:0] in_pix [LANES];
  logic [PIX_W-1:0] quad   [LANES];

  assign in_pix[0] = req.pixel_top_left;
  assign in_pix[1] = req.pixel_top_right;
  assign in_pix[2] = req.pixel_bottom_left;
  assign in_pix[3] = req.pixel_bottom_right;

  always_ff @(posedge clk) begin
    if (search_start) begin
      for (int l = 0; l < LANES; l++) begin
        quad[l] <= in_pix[l];
      end
    end
  end

  // tags follow the memory read and the lane distance register
  tag_t tag0;
  tag_t tag_d1;
  tag_t tag_d2;

  always_comb begin
    tag0.valid = rd_en;
    tag0.first = (cnt == '0);
    tag0.last  = (cnt == last_addr);
    tag0.index = IDX_W'(cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_d1 <= '0;
      tag_d2 <= '0;
    end else begin
      tag_d1 <= tag0;
      tag_d2 <= tag_d1;
    end
  end

  // one lane per quad pixel, each with its own slice of the codebook
  logic [LANE_DIST_W-1:0] lane_dist [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    vqncs_lane #(
      .CODEBOOK_DEPTH (CODEBOOK_DEPTH),
      .AW             (AW)
    ) u_lane (
      .clk        (clk),
      .wr_en      (wr_en),
      .wr_addr    (req.entry_index[AW-1:0]),
      .wr_data    (in_pix[l]),
      .rd_en      (rd_en),
      .rd_addr    (cnt),
      .quad_pixel (quad[l]),
      .pix_dist   (lane_dist[l])
    );
  end

  logic [IDX_W-1:0]  best_index;
  logic [DIST_W-1:0] best_dist;

  vqncs_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .tag_in     (tag_d2),
    .lane_dist  (lane_dist),
    .best_index (best_index),
    .best_dist  (best_dist),
    .done       (done)
  );

  // output register
  logic              out_valid;
  logic [IDX_W-1:0]  out_index;
  logic [DIST_W-1:0] out_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index <= best_index;
      out_dist  <= best_dist;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.code_index       = out_index;
  assign rsp.distance_squared = out_dist;

  // checks
  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_DRAIN))
    else $error("merge finished outside drain");

  a_rsp_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_HOLD))
    else $error("response raised without a finished search");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (cnt <= last_addr))
    else $error("entry counter ran past the last entry");

  a_no_read_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |=> !tag_d1.valid)
    else $error("codebook read while idle");

endmodule

`default_nettype wire

// ----- sv/vqncs_lane.sv -----
// vqncs_lane: one pixel of every codebook entry plus its distance unit
// depends on vqncs_pkg
`default_nettype none

module vqncs_lane
  import vqncs_pkg::*;
#(
  parameter int CODEBOOK_DEPTH = DEFAULT_CODEBOOK_DEPTH,
  parameter int AW             = $clog2(CODEBOOK_DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [AW-1:0]          wr_addr,
  input  wire logic [PIX_W-1:0]       wr_data,
  input  wire logic                   rd_en,
  input  wire logic [AW-1:0]          rd_addr,
  input  wire logic [PIX_W-1:0]       quad_pixel,
  output      logic [LANE_DIST_W-1:0] pix_dist
);

  logic [PIX_W-1:0] mem [CODEBOOK_DEPTH];
  logic [PIX_W-1:0] rd_data;
  logic [LANE_DIST_W-1:0] pix_dist_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // four channel squares summed
  always_comb begin
    logic [CH_W-1:0] a;
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] d;
    logic [2*CH_W-1:0] sq;
    pix_dist_next = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      a = rd_data[c*CH_W +: CH_W];
      b = quad_pixel[c*CH_W +: CH_W];
      d = (a > b) ? (a - b) : (b - a);
      sq = {{CH_W{1'b0}}, d} * {{CH_W{1'b0}}, d};
      pix_dist_next = pix_dist_next + LANE_DIST_W'(sq);
    end
  end

  always_ff @(posedge clk) begin
    pix_dist <= pix_dist_next;
  end

endmodule

`default_nettype wire

// ----- sv/vqncs_merge.sv -----
// vqncs_merge: adds the lane distances and keeps the running best entry
// depends on vqncs_pkg
`default_nettype none

module vqncs_merge
  import vqncs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire tag_t                   tag_in,
  input  wire logic [LANE_DIST_W-1:0] lane_dist [LANES],
  output      logic [IDX_W-1:0]       best_index,
  output      logic [DIST_W-1:0]      best_dist,
  output      logic                   done
);

  logic [DIST_W-1:0] sum_next;
  logic [DIST_W-1:0] sum;
  tag_t              tag_s;

  always_comb begin
    sum_next = '0;
    for (int l = 0; l < LANES; l++) begin
      sum_next = sum_next + DIST_W'(lane_dist[l]);
    end
  end

  always_ff @(posedge clk) begin
    sum <= sum_next;
    if (rst) begin
      tag_s <= '0;
    end else begin
      tag_s <= tag_in;
    end
  end

  // strict less-than keeps the lowest-numbered entry on ties
  always_ff @(posedge clk) begin
    if (tag_s.valid && (tag_s.first || sum < best_dist)) begin
      best_index <= tag_s.index;
      best_dist  <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag_s.valid && tag_s.last;
    end
  end

endmodule

`default_nettype wire

// ----- bench/vq_nearest_codeword_search_checker.sv -----
// result checker for vq_nearest_codeword_search: watches the req, rsp and cfg channels
// keeps its own codebook copy and predicts each search result in order
// depends on vqncs_pkg and vqncs_if
`default_nettype none

module vq_nearest_codeword_search_checker
  import vqncs_pkg::*;
#(
  parameter int CODEBOOK_DEPTH = DEFAULT_CODEBOOK_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  vqncs_req_if      req,
  vqncs_rsp_if      rsp,
  vqncs_cfg_if      cfg,
  output int        pending,
  output int        mismatches,
  output int        searches_checked
);

  typedef logic [LANES-1:0][PIX_W-1:0] quad_t;

  typedef struct packed {
    logic [IDX_W-1:0]  code_index;
    logic [DIST_W-1:0] distance_squared;
  } code_match_t;

  quad_t            codebook [CODEBOOK_DEPTH];
  logic [CNT_W-1:0] entries_in_use = ENTRIES_RESET;
  code_match_t      expected_matches [$];
  int               mismatch_count = 0;
  int               checked_count = 0;

  // sum of squared channel differences over the whole quad
  function automatic logic [DIST_W-1:0] quad_distance(quad_t a, quad_t b);
    logic [DIST_W-1:0] sum;
    logic [CH_W-1:0]   ca;
    logic [CH_W-1:0]   cb;
    logic [CH_W-1:0]   diff;
    sum = '0;
    for (int lane = 0; lane < LANES; lane++) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        ca   = a[lane][ch*CH_W +: CH_W];
        cb   = b[lane][ch*CH_W +: CH_W];
        diff = (ca > cb) ? ca - cb : cb - ca;
        sum  = sum + DIST_W'(diff) * DIST_W'(diff);
      end
    end
    return sum;
  endfunction

  // first entry with the smallest distance among the entries in use
  function automatic code_match_t nearest_codeword(quad_t q);
    code_match_t       best;
    int                count;
    logic [DIST_W-1:0] d;
    count = int'(entries_in_use);
    if (count < 1) count = 1;
    if (count > CODEBOOK_DEPTH) count = CODEBOOK_DEPTH;
    best.code_index       = '0;
    best.distance_squared = quad_distance(codebook[0], q);
    for (int e = 1; e < count; e++) begin
      d = quad_distance(codebook[e], q);
      if (d < best.distance_squared) begin
        best.code_index       = IDX_W'(e);
        best.distance_squared = d;
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    code_match_t got;
    code_match_t want;
    quad_t       q;
    if (rst) begin
      expected_matches.delete();
      entries_in_use = ENTRIES_RESET;
    end else begin
      if (cfg.valid && cfg.ready) entries_in_use = cfg.data;

      // results first, so one leaving and one arriving on the same edge stay in order
      if (rsp.valid && rsp.ready) begin
        got.code_index       = rsp.code_index;
        got.distance_squared = rsp.distance_squared;
        if (expected_matches.size() == 0) begin
          $error("unexpected result transaction: code_index %0d distance_squared %0d",
                 got.code_index, got.distance_squared);
          mismatch_count++;
        end else begin
          want = expected_matches.pop_front();
          checked_count++;
          if (got.code_index !== want.code_index) begin
            $error("code_index: expected %0d, actual %0d", want.code_index, got.code_index);
            mismatch_count++;
          end
          if (got.distance_squared !== want.distance_squared) begin
            $error("distance_squared: expected %0d, actual %0d",
                   want.distance_squared, got.distance_squared);
            mismatch_count++;
          end
        end
      end

      if (req.valid && req.ready) begin
        q = {req.pixel_bottom_right, req.pixel_bottom_left,
             req.pixel_top_right, req.pixel_top_left};
        if (req.func == FUNC_LOAD) begin
          if (int'(req.entry_index) < CODEBOOK_DEPTH) codebook[req.entry_index] = q;
        end else begin
          expected_matches.push_back(nearest_codeword(q));
        end
      end
    end
    pending          <= expected_matches.size();
    mismatches       <= mismatch_count;
    searches_checked <= checked_count;
  end

endmodule

`default_nettype wire

// ----- bench/vq_nearest_codeword_search_test.sv -----
// top of the vq_nearest_codeword_search testbench: clock, reset, stimulus and verdict
// depends on vqncs_pkg, vqncs_if, the block and vq_nearest_codeword_search_checker
`default_nettype none

module vq_nearest_codeword_search_test;
  import vqncs_pkg::*;

  localparam int DEPTH          = DEFAULT_CODEBOOK_DEPTH;
  localparam int ITEMS_PER_SIZE = 86;
  localparam int DRAIN_LIMIT    = 20000;

  typedef logic [LANES-1:0][PIX_W-1:0] quad_t;

  logic clk;
  logic rst;

  vqncs_req_if req_ch ();
  vqncs_rsp_if rsp_ch ();
  vqncs_cfg_if cfg_ch ();

  int pending_results;
  int mismatches;
  int searches_checked;

  // shadow of what was loaded, used to aim searches at real codewords and to repeat entries
  quad_t book [DEPTH];
  int    loads_sent = 0;
  int    searches_sent = 0;
  int    sizes_tried = 0;
  bit    tx_burst = 1'b0;
  bit    rx_burst = 1'b0;

  // codebook sizes walked by the random part: extremes, saturation and zero among them
  int size_plan [12] = '{256, 7, 511, 1, 64, 257, 0, 200, 2, 256, 128, 3};

  vq_nearest_codeword_search #(
    .CODEBOOK_DEPTH(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  vq_nearest_codeword_search_checker #(
    .CODEBOOK_DEPTH(DEPTH)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch),
    .pending(pending_results),
    .mismatches(mismatches),
    .searches_checked(searches_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #15_000_000;
    $display("vq_nearest_codeword_search_test: FAIL");
    $finish;
  end

  // result side: after each transaction draw a stall, counted only while a result waits;
  // now and then flip into a stretch where ready never drops
  initial begin
    int unsigned stall;
    stall = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
        stall = 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
        if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        stall = rx_burst ? 0 : $urandom_range(0, 19);
        rsp_ch.ready <= (stall == 0);
      end else if (stall > 0) begin
        if (rsp_ch.valid) begin
          stall--;
          rsp_ch.ready <= (stall == 0);
        end
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  function automatic quad_t solid_quad(logic [PIX_W-1:0] px);
    return {LANES{px}};
  endfunction

  // channels from a few hard levels, so different entries often tie
  function automatic logic [PIX_W-1:0] palette_pixel();
    logic [CH_W-1:0]  levels [6];
    logic [PIX_W-1:0] px;
    levels = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hfe, 8'hff};
    for (int ch = 0; ch < CHANNELS; ch++) px[ch*CH_W +: CH_W] = levels[$urandom_range(0, 5)];
    return px;
  endfunction

  // flavor 0 full random, 1 palette, 2 narrow mid-gray band, else extreme pixels per lane
  function automatic quad_t random_quad(int unsigned flavor);
    quad_t            q;
    logic [PIX_W-1:0] extremes [4];
    extremes = '{32'h0000_0000, 32'hffff_ffff, 32'hff00_ff00, 32'h00ff_00ff};
    for (int lane = 0; lane < LANES; lane++) begin
      case (flavor)
        0: begin
          q[lane] = $urandom();
        end
        1: begin
          q[lane] = palette_pixel();
        end
        2: begin
          for (int ch = 0; ch < CHANNELS; ch++)
            q[lane][ch*CH_W +: CH_W] = 8'h78 + CH_W'($urandom_range(0, 15));
        end
        default: begin
          q[lane] = extremes[$urandom_range(0, 3)];
        end
      endcase
    end
    return q;
  endfunction

  // small disturbance of a codeword: flip low bits of one or two channels
  function automatic quad_t nudge(quad_t q);
    int lane;
    int ch;
    repeat ($urandom_range(1, 2)) begin
      lane = $urandom_range(0, LANES - 1);
      ch   = $urandom_range(0, CHANNELS - 1);
      q[lane][ch*CH_W +: 2] = q[lane][ch*CH_W +: 2] ^ 2'($urandom_range(1, 3));
    end
    return q;
  endfunction

  // one request transaction; called right after the clock rises
  task automatic send_item(input logic func, input logic [IDX_W-1:0] idx, input quad_t q);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid              <= 1'b1;
    req_ch.func               <= func;
    req_ch.entry_index        <= idx;
    req_ch.pixel_top_left     <= q[0];
    req_ch.pixel_top_right    <= q[1];
    req_ch.pixel_bottom_left  <= q[2];
    req_ch.pixel_bottom_right <= q[3];
    do @(posedge clk); while (!req_ch.ready);
    if (func == FUNC_LOAD) begin
      book[idx] = q;
      loads_sent++;
    end else begin
      searches_sent++;
    end
  endtask

  // stop sending until every search has answered, then let a trailing load settle
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_entries_in_use(input logic [CNT_W-1:0] value);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sizes_tried++;
  endtask

  initial begin
    quad_t q;
    int    lim;
    int    sel;
    int    waited;
    int    idx;

    rst                       = 1'b1;
    req_ch.valid              = 1'b0;
    req_ch.func               = FUNC_LOAD;
    req_ch.entry_index        = '0;
    req_ch.pixel_top_left     = '0;
    req_ch.pixel_top_right    = '0;
    req_ch.pixel_bottom_left  = '0;
    req_ch.pixel_bottom_right = '0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.data               = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: a zero size means one entry, so only entry zero must exist
    write_entries_in_use(0);
    send_item(FUNC_LOAD, 0, solid_quad(32'h0000_0000));
    send_item(FUNC_SEARCH, 8'hff, solid_quad(32'hffff_ffff));   // largest distance
    send_item(FUNC_SEARCH, 0, solid_quad(32'h0000_0000));       // exact match
    send_item(FUNC_LOAD, 8'hff, solid_quad(32'hffff_ffff));     // top entry index
    send_item(FUNC_SEARCH, 0, solid_quad(32'h0102_0304));

    // entry one loaded but outside the searched range
    write_entries_in_use(1);
    send_item(FUNC_LOAD, 1, solid_quad(32'hffff_ffff));
    send_item(FUNC_SEARCH, 0, solid_quad(32'hffff_ffff));

    // two entries: exact match on the second, then a tie that the lower entry wins
    write_entries_in_use(2);
    send_item(FUNC_SEARCH, 0, solid_quad(32'hffff_ffff));
    send_item(FUNC_LOAD, 0, solid_quad(32'hffff_ffff));
    send_item(FUNC_SEARCH, 0, solid_quad(32'hffff_ffff));
    send_item(FUNC_SEARCH, 0, solid_quad(32'h0000_0000));
    send_item(FUNC_LOAD, 1, solid_quad(32'h0000_0000));
    send_item(FUNC_SEARCH, 0, solid_quad(32'h8080_8080));

    // fill the whole codebook so no later search reads an unwritten entry;
    // some entries repeat earlier ones to make ties
    for (int e = 0; e < DEPTH; e++) begin
      if (e > 0 && $urandom_range(0, 7) == 0) q = book[$urandom_range(0, e - 1)];
      else q = random_quad($urandom_range(0, 2));
      send_item(FUNC_LOAD, IDX_W'(e), q);
    end

    // random part, one stretch per codebook size
    foreach (size_plan[ph]) begin
      write_entries_in_use(CNT_W'(size_plan[ph]));
      lim = size_plan[ph];
      if (lim < 1) lim = 1;
      if (lim > DEPTH) lim = DEPTH;
      repeat (ITEMS_PER_SIZE) begin
        if ($urandom_range(0, 9) < 3) begin
          // reload: mostly inside the searched range
          idx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, lim - 1)
                                           : $urandom_range(0, DEPTH - 1);
          if ($urandom_range(0, 3) == 0) q = book[$urandom_range(0, DEPTH - 1)];
          else q = random_quad($urandom_range(0, 2));
          send_item(FUNC_LOAD, IDX_W'(idx), q);
        end else begin
          sel = $urandom_range(0, 19);
          if (sel < 6) q = book[$urandom_range(0, lim - 1)];
          else if (sel < 11) q = nudge(book[$urandom_range(0, lim - 1)]);
          else if (sel < 13) q = book[$urandom_range(0, DEPTH - 1)];
          else if (sel < 16) q = random_quad($urandom_range(1, 2));
          else if (sel < 18) q = random_quad(0);
          else q = random_quad(3);
          send_item(FUNC_SEARCH, IDX_W'($urandom_range(0, 255)), q);
        end
        // occasionally hold off until the block has answered everything
        if ($urandom_range(0, 39) == 0) wait_idle();
      end
    end

    req_ch.valid <= 1'b0;

    // drain outstanding searches, bounded
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_results != 0 && waited < DRAIN_LIMIT);

    if (pending_results != 0) begin
      $error("%0d searches never answered", pending_results);
      $display("vq_nearest_codeword_search_test: FAIL");
      $finish;
    end else begin
      // one full search worth of quiet to catch stray results
      repeat (300) @(posedge clk);
      $display("covered %0d codebook loads and %0d searches over %0d entries_in_use settings",
               loads_sent, searches_sent, sizes_tried);
      $display("%0d search results compared, %0d mismatches", searches_checked, mismatches);
      if (mismatches == 0) begin
        $display("vq_nearest_codeword_search_test: PASS");
      end else begin
        $display("vq_nearest_codeword_search_test: FAIL");
      end
      $finish;
    end
  end

endmodule

`default_nettype wire
